// ----- sv/itp_pkg.sv -----
// ----------------------------------------------------------------------------
// itp_pkg
// Character codes and digit decode for the integer text parser.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam logic [5:0] BASE_AUTO  = 6'd0;
    localparam logic [5:0] BASE_MIN   = 6'd2;
    localparam logic [5:0] BASE_MAX   = 6'd36;
    localparam logic [5:0] BASE_OCT   = 6'd8;
    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_HEX   = 6'd16;
    localparam logic [5:0] NO_DIGIT   = 6'd63;

    localparam int VALUE_W  = 64;
    localparam int OFFSET_W = 13;
    localparam int COUNT_LIMIT = 8191;

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [5:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = 6'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = 6'(c - CH_LO_A) + 6'd10;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = 6'(c - CH_UP_A) + 6'd10;
        end
        return d;
    endfunction

endpackage

// ----- sv/integer_text_parser_unit.sv -----
// ----------------------------------------------------------------------------
// integer_text_parser_unit
// Character-serial text-to-integer converter with optional sign and base
// detection. One byte per beat in, one result beat per parsed number.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries one character per beat with
//   i_start_req marking the first character of a number. Output channel
//   (o_out_valid/i_out_ready) carries one result beat when the first
//   non-digit or NUL ends a number. Config channel (i_cfg_valid/o_cfg_ready)
//   writes the base: 0 auto-detects, 2 to 36 fixed; reset value is 10.
//   Write the base only while the block is idle; it is taken at each start.
// Timing:
//   A beat lands in the input register; then a single stage of digit decode
//   and a 64x6 multiply-add updates the parse state and the result register.
//   A result is valid once that stage has taken its ending beat; throughput
//   is one character per cycle while no held result stalls the stage.
// Reset and stall:
//   Reset empties both registers, sets the base to 10 and waits for a start.
//   While the receiver stalls a held result, no character is processed; an
//   empty input register still takes one beat, then o_in_ready drops.
// ----------------------------------------------------------------------------
module integer_text_parser_unit #(
    parameter int MAX_LEN = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_start_req,
    input  logic [7:0]                    i_char_code,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [itp_pkg::VALUE_W-1:0]  o_value,
    output logic [itp_pkg::OFFSET_W-1:0]  o_end_offset,
    output logic                          o_overflow,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [5:0]                    i_base_setting
);
    import itp_pkg::*;

    localparam int CAP_INT = (MAX_LEN < COUNT_LIMIT) ? MAX_LEN : COUNT_LIMIT;
    localparam logic [OFFSET_W-1:0] CNT_CAP = OFFSET_W'(CAP_INT);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_FIRST,
        PH_ZERO,
        PH_DIGITS
    } t_phase_e;

    logic [5:0]            r_cfg_base;
    logic                  r_in_valid;
    logic                  r_in_start;
    logic [7:0]            r_in_char;
    t_phase_e              r_phase,    n_phase;
    logic                  r_negative, n_negative;
    logic [5:0]            r_base,     n_base;
    logic                  r_zpp,      n_zpp;
    logic [VALUE_W-1:0]    r_acc,      n_acc;
    logic [OFFSET_W-1:0]   r_cnt,      n_cnt;
    logic                  r_ovf,      n_ovf;
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_value,    n_value;
    logic [OFFSET_W-1:0]   r_offset,   n_offset;
    logic                  r_out_ovf;
    logic                  n_emit;
    logic                  proc_go;

    assign proc_go     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || proc_go;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_value     = signed'(r_value);
    assign o_end_offset = r_offset;
    assign o_overflow  = r_out_ovf;

    always_comb begin
        logic [5:0]          d;
        logic                do_first;
        logic                do_dig;
        logic                base_ok;
        logic [VALUE_W+5:0]  prod;
        logic [OFFSET_W-1:0] cnt_bump;

        n_phase    = r_phase;
        n_negative = r_negative;
        n_base     = r_base;
        n_zpp      = r_zpp;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_ovf      = r_ovf;
        n_emit     = 1'b0;
        n_offset   = '0;
        do_first   = 1'b0;
        do_dig     = 1'b0;
        d          = digit_of(r_in_char);

        if (r_in_start) begin
            n_phase    = PH_LEAD;
            n_negative = 1'b0;
            n_base     = r_cfg_base;
            n_zpp      = 1'b0;
            n_acc      = '0;
            n_cnt      = '0;
            n_ovf      = 1'b0;
        end

        cnt_bump = (n_cnt < CNT_CAP) ? n_cnt + 1'b1 : n_cnt;

        unique case (n_phase)
            PH_LEAD: begin
                if (r_in_char == CH_SPACE || r_in_char == CH_TAB) begin
                    n_cnt = cnt_bump;
                end else if (r_in_char == CH_MINUS || r_in_char == CH_PLUS) begin
                    n_negative = (r_in_char == CH_MINUS);
                    n_cnt      = cnt_bump;
                    n_phase    = PH_FIRST;
                end else begin
                    do_first = 1'b1;
                end
            end
            PH_FIRST: begin
                do_first = 1'b1;
            end
            PH_ZERO: begin
                if (r_in_char == CH_LO_X || r_in_char == CH_UP_X) begin
                    n_base  = BASE_HEX;
                    n_cnt   = cnt_bump;
                    n_zpp   = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    if (n_base == BASE_AUTO) begin
                        n_base = BASE_OCT;
                    end
                    do_dig = 1'b1;
                end
            end
            PH_DIGITS: begin
                do_dig = 1'b1;
            end
            default: begin
            end
        endcase

        base_ok = (n_base == BASE_AUTO) || (n_base >= BASE_MIN && n_base <= BASE_MAX);
        if (do_first) begin
            if (!base_ok) begin
                n_emit = 1'b1;
            end else if (r_in_char == CH_ZERO &&
                         (n_base == BASE_AUTO || n_base == BASE_HEX)) begin
                n_acc   = '0;
                n_cnt   = cnt_bump;
                n_phase = PH_ZERO;
            end else begin
                if (n_base == BASE_AUTO) begin
                    n_base = BASE_DEC;
                end
                if (d < n_base) begin
                    do_dig = 1'b1;
                end else begin
                    n_emit = 1'b1;
                end
            end
        end

        prod = (VALUE_W+6)'(n_acc) * (VALUE_W+6)'(n_base) + (VALUE_W+6)'(d);
        if (do_dig) begin
            if (d < n_base) begin
                if (prod[VALUE_W+5:VALUE_W] != '0) begin
                    n_ovf = 1'b1;
                end
                n_acc   = prod[VALUE_W-1:0];
                n_cnt   = cnt_bump;
                n_zpp   = 1'b0;
                n_phase = PH_DIGITS;
            end else begin
                n_emit   = 1'b1;
                n_offset = n_zpp ? n_cnt - 1'b1 : n_cnt;
            end
        end

        if (n_emit) begin
            n_phase = PH_IDLE;
        end
        n_value = n_negative ? VALUE_W'(0) - n_acc : n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base     <= BASE_DEC;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_phase        <= PH_IDLE;
            r_negative     <= 1'b0;
            r_base         <= BASE_DEC;
            r_zpp          <= 1'b0;
            r_acc          <= '0;
            r_cnt          <= '0;
            r_ovf          <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg_base <= i_base_setting;
            end
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (proc_go) begin
                r_in_valid <= 1'b0;
            end
            if (proc_go) begin
                r_phase     <= n_phase;
                r_negative  <= n_negative;
                r_base      <= n_base;
                r_zpp       <= n_zpp;
                r_acc       <= n_acc;
                r_cnt       <= n_cnt;
                r_ovf       <= n_ovf;
                r_out_valid <= n_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_start <= i_start_req;
            r_in_char  <= i_char_code;
        end
        if (proc_go && n_emit) begin
            r_value   <= n_value;
            r_offset  <= n_offset;
            r_out_ovf <= n_ovf;
        end
    end

endmodule

// ----- bench/parse_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// parse_result_checker
// Watches the character, result and base channels of the integer text
// parser, tracks the parse of every accepted character, queues the numbers
// that must come out and compares each result beat with the oldest of them.
// ----------------------------------------------------------------------------
module parse_result_checker #(
    parameter int MAX_LEN = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_start_req,
    input  logic [7:0]          i_char_code,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic signed [63:0]  i_value,
    input  logic [12:0]         i_end_offset,
    input  logic                i_overflow,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [5:0]          i_base_setting,
    output int                  o_fail_count,
    output int                  o_pending
);
    import itp_pkg::*;

    localparam int COUNT_CAP = (MAX_LEN < COUNT_LIMIT) ? MAX_LEN : COUNT_LIMIT;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_FIRST,
        PH_ZERO,
        PH_DIGITS
    } t_parse_phase;

    typedef struct packed {
        logic signed [63:0] value;
        logic [12:0]        end_offset;
        logic               overflow;
    } t_parsed_number;

    t_parsed_number parsed_numbers_due[$];

    logic [5:0]   base_reg     = BASE_DEC;
    t_parse_phase phase        = PH_IDLE;
    logic         negative     = 1'b0;
    logic [5:0]   radix        = BASE_DEC;
    logic         zero_pending = 1'b0;
    logic [63:0]  acc          = '0;
    logic [12:0]  char_count   = '0;
    logic         wrapped      = 1'b0;
    int           results_seen = 0;
    int           mismatches   = 0;

    function automatic logic [5:0] char_digit(input logic [7:0] c);
        logic [5:0] d;
        d = NO_DIGIT;
        case (1'b1)
            (c >= CH_ZERO && c <= CH_NINE): d = 6'(c - CH_ZERO);
            (c >= CH_LO_A && c <= CH_LO_Z): d = 6'(c - CH_LO_A + 8'd10);
            (c >= CH_UP_A && c <= CH_UP_Z): d = 6'(c - CH_UP_A + 8'd10);
            default: d = NO_DIGIT;
        endcase
        return d;
    endfunction

    function automatic void count_char();
        if (char_count < 13'(COUNT_CAP)) char_count = char_count + 13'd1;
    endfunction

    function automatic void finish_number(input logic [12:0] offset);
        t_parsed_number r;
        r.value      = negative ? -acc : acc;
        r.end_offset = offset;
        r.overflow   = wrapped;
        parsed_numbers_due.push_back(r);
        phase = PH_IDLE;
    endfunction

    function automatic void digit_or_end(input logic [7:0] c);
        logic [5:0]  d;
        logic [71:0] wide;
        d = char_digit(c);
        if (d < radix) begin
            wide = {8'd0, acc} * {66'd0, radix} + {66'd0, d};
            if (wide[71:64] != 8'd0) wrapped = 1'b1;
            acc = wide[63:0];
            count_char();
            zero_pending = 1'b0;
            phase = PH_DIGITS;
        end else begin
            finish_number(zero_pending ? char_count - 13'd1 : char_count);
        end
    endfunction

    function automatic void first_digit(input logic [7:0] c);
        if (!(radix == BASE_AUTO || (radix >= BASE_MIN && radix <= BASE_MAX))) begin
            finish_number(13'd0);
        end else if (c == CH_ZERO && (radix == BASE_AUTO || radix == BASE_HEX)) begin
            acc = '0;
            count_char();
            phase = PH_ZERO;
        end else begin
            if (radix == BASE_AUTO) radix = BASE_DEC;
            if (char_digit(c) < radix) digit_or_end(c);
            else finish_number(13'd0);
        end
    endfunction

    function automatic void parse_step(input logic start, input logic [7:0] c);
        if (start) begin
            negative     = 1'b0;
            zero_pending = 1'b0;
            acc          = '0;
            char_count   = '0;
            wrapped      = 1'b0;
            radix        = base_reg;
            phase        = PH_LEAD;
        end
        case (phase)
            PH_LEAD: begin
                if (c == CH_SPACE || c == CH_TAB) begin
                    count_char();
                end else if (c == CH_MINUS || c == CH_PLUS) begin
                    negative = (c == CH_MINUS);
                    count_char();
                    phase = PH_FIRST;
                end else begin
                    first_digit(c);
                end
            end
            PH_FIRST: first_digit(c);
            PH_ZERO: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    radix = BASE_HEX;
                    count_char();
                    zero_pending = 1'b1;
                    phase = PH_DIGITS;
                end else begin
                    if (radix == BASE_AUTO) radix = BASE_OCT;
                    digit_or_end(c);
                end
            end
            PH_DIGITS: digit_or_end(c);
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_parsed_number want;
        if (!i_rst_n) begin
            base_reg     = BASE_DEC;
            phase        = PH_IDLE;
            negative     = 1'b0;
            radix        = BASE_DEC;
            zero_pending = 1'b0;
            acc          = '0;
            char_count   = '0;
            wrapped      = 1'b0;
            parsed_numbers_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (parsed_numbers_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: no number pending, got value %0d",
                                 results_seen, i_value,
                                 " offset %0d ovf %0b", i_end_offset, i_overflow);
                end else begin
                    want = parsed_numbers_due.pop_front();
                    if (i_value !== want.value || i_end_offset !== want.end_offset ||
                        i_overflow !== want.overflow) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected value %0d offset %0d ovf %0b,",
                                     results_seen, want.value, want.end_offset,
                                     want.overflow,
                                     " got value %0d offset %0d ovf %0b",
                                     i_value, i_end_offset, i_overflow);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) base_reg = i_base_setting;
            if (i_in_valid && i_in_ready) parse_step(i_start_req, i_char_code);
        end
        o_fail_count = mismatches;
        o_pending    = parsed_numbers_due.size();
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the integer text parser with a short directed set of strings, then
// random well-formed numbers mixed with noise over many base settings and
// three idle patterns. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module testbench;
    import itp_pkg::*;

    localparam int         CYCLE_LIMIT = 1000000;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_DOT      = 8'h2E;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                start_req   = 1'b0;
    logic [7:0]          char_code   = '0;
    logic                out_ready   = 1'b0;
    logic                cfg_valid   = 1'b0;
    logic [5:0]          base_value  = BASE_DEC;
    logic                in_ready;
    logic                out_valid;
    logic signed [63:0]  value;
    logic [12:0]         end_offset;
    logic                overflow;
    logic                cfg_ready;

    int   send_idle   = 8;
    int   recv_idle   = 76;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   text_chars  = 0;
    logic opening     = 1'b0;

    always #10 clk = ~clk;

    integer_text_parser_unit #(.MAX_LEN(4096)) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_start_req    (start_req),
        .i_char_code    (char_code),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_value        (value),
        .o_end_offset   (end_offset),
        .o_overflow     (overflow),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_base_setting (base_value)
    );

    parse_result_checker #(.MAX_LEN(4096)) result_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_start_req    (start_req),
        .i_char_code    (char_code),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_value        (value),
        .i_end_offset   (end_offset),
        .i_overflow     (overflow),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_base_setting (base_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_char(input logic s, input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= s;
        char_code <= c;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic put(input logic [7:0] c);
        send_char(opening, c);
        opening = 1'b0;
        text_chars++;
    endtask

    // drain results, then let the pipeline settle before touching the base
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_base(input logic [5:0] b);
        wait_quiet();
        cfg_valid  <= 1'b1;
        base_value <= b;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] digit_char(input logic [5:0] d);
        if (d < 6'd10) return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + 8'(d) - 8'd10;
    endfunction

    task automatic send_number(input logic [5:0] b);
        logic [5:0] radix;
        int         span;
        int         r;
        radix   = (b >= BASE_MIN && b <= BASE_MAX) ? b : BASE_DEC;
        opening = 1'b1;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) put($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        r = $urandom_range(0, 2);
        if (r == 1) put(CH_PLUS);
        else if (r == 2) put(CH_MINUS);
        if ((b == BASE_AUTO || b == BASE_HEX) && $urandom_range(0, 1)) begin
            put(CH_ZERO);
            if ($urandom_range(0, 2) != 0) begin
                put($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                radix = BASE_HEX;
            end else if (b == BASE_AUTO) begin
                radix = BASE_OCT;
            end
        end
        r = $urandom_range(0, 9);
        span = (r == 0) ? 70 : (r < 3) ? 24 : 6;
        repeat ($urandom_range(0, span)) begin
            // restart mid-number now and then
            if ($urandom_range(0, 59) == 0) opening = 1'b1;
            put(digit_char(6'($urandom_range(0, radix - 1))));
        end
        case ($urandom_range(0, 3))
            0: put(CH_NUL);
            1: put(radix < BASE_MAX ? digit_char(radix) : CH_DOT);
            2: put(8'($urandom));
            default: put($urandom_range(0, 1) ? CH_SPACE : CH_MINUS);
        endcase
    endtask

    initial begin
        logic [5:0] base_plan [9];
        logic [5:0] cur_base;
        int         goal;
        base_plan = '{BASE_AUTO, BASE_DEC, BASE_HEX, BASE_MIN, BASE_MAX, BASE_OCT,
                      6'd1, 6'd37, 6'd63};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_char(1'b0, CH_UP_A);
        send_char(1'b1, CH_SPACE);
        send_char(1'b0, CH_TAB);
        send_char(1'b0, CH_MINUS);
        send_char(1'b0, "7");
        send_char(1'b0, CH_NUL);
        send_char(1'b1, "1");
        send_char(1'b0, "2");
        send_char(1'b1, "5");
        send_char(1'b0, ",");
        send_char(1'b1, CH_PLUS);
        send_char(1'b0, CH_NUL);
        send_char(1'b1, 8'hFF);
        send_char(1'b0, "9");
        write_base(BASE_AUTO);
        send_char(1'b1, CH_ZERO);
        send_char(1'b0, CH_LO_X);
        send_char(1'b0, "g");
        send_char(1'b1, CH_ZERO);
        send_char(1'b0, "7");
        send_char(1'b0, "9");
        send_char(1'b1, CH_ZERO);
        send_char(1'b0, CH_UP_X);
        send_char(1'b0, "f");
        send_char(1'b0, CH_NUL);
        write_base(BASE_MAX);
        send_char(1'b1, "z");
        send_char(1'b0, "Z");
        send_char(1'b0, CH_NUL);
        write_base(6'd63);
        send_char(1'b1, "5");

        for (int seg = 0; seg < 15; seg++) begin
            if (seg == 5) begin
                send_idle = 76;
                recv_idle = 8;
            end
            if (seg == 10) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (seg < 9) cur_base = base_plan[seg];
            else if ($urandom_range(0, 3) == 0) cur_base = 6'($urandom_range(0, 63));
            else cur_base = 6'($urandom_range(2, 36));
            write_base(cur_base);
            goal = text_chars + 85;
            while (text_chars < goal) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_number(cur_base);
                end else begin
                    repeat ($urandom_range(1, 4))
                        send_char($urandom_range(0, 7) == 0, 8'($urandom));
                end
            end
        end

        wait_quiet();
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/itp_pkg.sv
sv/integer_text_parser_unit.sv
bench/parse_result_checker.sv
bench/testbench.sv
